[rtl/core/mtf_pkg.sv]
// Package with the shared constants, codes and the token type of the move-to-front encoder.
`timescale 1ns / 1ps

package mtf_pkg;

  // Number of dictionary cells in the chain.
  localparam int DEPTH = 256;
  // Bits of a symbol that take part in matching.
  localparam int SYM_W = 8;
  // Bits needed to name one cell.
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Fixed widths of the port fields.
  localparam int SYMBOL_PORT_W = 8;
  localparam int INDEX_PORT_W  = 8;

  // Operation codes carried by an input transaction.
  typedef enum logic {
    OP_ENCODE  = 1'b0,
    OP_PRELOAD = 1'b1
  } mtf_op_t;

  // Wavefront token that walks the chain one cell per cycle while the chain is not frozen.
  typedef struct packed {
    logic             vld;      // token holds a transaction
    mtf_op_t          op;       // encode or preload
    logic [SYM_W-1:0] sym;      // symbol being searched or appended
    logic [SYM_W-1:0] carry;    // entry shifted back toward the end
    logic             done;     // the dictionary change has been made
    logic [IDX_W-1:0] idx;      // position where the search ended
    logic             was_new;  // symbol was not found
  } mtf_tok_t;

endpackage

[rtl/core/mtf_cell.sv]
// One dictionary cell: holds one entry and updates it as a token passes by.
`timescale 1ns / 1ps

module mtf_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [mtf_pkg::IDX_W-1:0] cell_pos,
  input  logic            is_last,
  input  mtf_pkg::mtf_tok_t tok_in,
  output mtf_pkg::mtf_tok_t tok_out
);
  import mtf_pkg::*;

  logic             entry_vld;
  logic [SYM_W-1:0] entry_sym;
  logic             entry_vld_next;
  logic [SYM_W-1:0] entry_sym_next;
  mtf_tok_t         tok_next;
  logic             active;
  logic             hit;
  logic             take;

  // A token works on this cell only until its change has been made.
  assign active = tok_in.vld && !tok_in.done;
  assign hit    = entry_vld && (entry_sym == tok_in.sym);
  assign take   = !entry_vld || hit || is_last;

  // Encode shifts the entry back until the match or the end is reached;
  // preload fills the first empty cell.
  always_comb begin
    tok_next       = tok_in;
    entry_vld_next = entry_vld;
    entry_sym_next = entry_sym;
    if (active) begin
      case (tok_in.op)
        OP_ENCODE: begin
          entry_sym_next = tok_in.carry;
          entry_vld_next = 1'b1;
          tok_next.carry = entry_sym;
          if (take) begin
            tok_next.done    = 1'b1;
            tok_next.idx     = cell_pos;
            tok_next.was_new = !hit;
          end
        end
        OP_PRELOAD: begin
          if (!entry_vld) begin
            entry_sym_next = tok_in.sym;
            entry_vld_next = 1'b1;
            tok_next.done  = 1'b1;
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  // Entry and token registers advance together with the whole chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= 1'b0;
      tok_out   <= '0;
    end else if (en) begin
      entry_vld <= entry_vld_next;
      tok_out   <= tok_next;
    end
  end

  // The entry symbol needs no reset; its valid bit guards it.
  always_ff @(posedge clk) begin
    if (en) begin
      entry_sym <= entry_sym_next;
    end
  end

endmodule

[rtl/core/move_to_front_encoder.sv]
// Top level of the move-to-front encoder: a chain of dictionary cells and an output register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------
//   in      | input     | in_valid / in_stall   | opcode, symbol
//   out     | output    | out_valid / out_stall | index, was_new
//
// One transaction enters per cycle while in_stall is low. Each transaction walks the DEPTH
// cells one cell per cycle while the chain is not frozen; an encode result then passes
// through the output register after the last cell before it is offered.
// Preload transactions walk the chain too but give no result.
// Reset empties the dictionary at once; no clearing pass is needed.
// While out_valid is held by out_stall the whole chain freezes and in_stall is high.
`timescale 1ns / 1ps

module move_to_front_encoder (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic opcode,
  input  logic [mtf_pkg::SYMBOL_PORT_W-1:0] symbol,
  output logic out_valid,
  input  logic out_stall,
  output logic [mtf_pkg::INDEX_PORT_W-1:0] index,
  output logic was_new
);
  import mtf_pkg::*;

  mtf_tok_t tok [0:DEPTH];
  logic     advance;
  mtf_tok_t last_tok;

  // The chain moves whenever the output register is free or being emptied.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // Build the entry token for the first cell.
  always_comb begin
    tok[0]         = '0;
    tok[0].vld     = in_valid;
    tok[0].op      = mtf_op_t'(opcode);
    tok[0].sym     = symbol[SYM_W-1:0];
    tok[0].carry   = symbol[SYM_W-1:0];
    tok[0].done    = 1'b0;
    tok[0].idx     = '0;
    tok[0].was_new = 1'b0;
  end

  // Row of identical dictionary cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mtf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .cell_pos (IDX_W'(i)),
      .is_last  ((i == DEPTH - 1) ? 1'b1 : 1'b0),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  assign last_tok = tok[DEPTH];

  // Output register: only encode transactions produce a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= last_tok.vld && (last_tok.op == OP_ENCODE);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      index   <= INDEX_PORT_W'(last_tok.idx);
      was_new <= last_tok.was_new;
    end
  end

endmodule

[rtl/core/mtf_checker.sv]
// Port-level checks of the move-to-front encoder and the bind that attaches them.
`timescale 1ns / 1ps

module mtf_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [mtf_pkg::INDEX_PORT_W-1:0] index,
  input logic was_new
);
  import mtf_pkg::*;

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(index) && $stable(was_new))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // The input side stalls exactly when a result is held back.
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output stall");

  // A result leaving the block frees the input side in the same cycle.
  a_taken_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while the result is taken");

endmodule

bind move_to_front_encoder mtf_checker u_mtf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .index     (index),
  .was_new   (was_new)
);
